@@ rtl/core/rsi_pkg.sv @@
// Ray-sphere intersect package: widths, payload structs and inter-stage bundles.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rsi_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DistBits   = 31;
  localparam int unsigned RadWidth   = CoordWidth - 1;

  // origin minus center
  localparam int unsigned OcWidth   = CoordWidth + 1;
  // a = D.D (unsigned), h = D.OC (signed), c = OC.OC - R*R (signed)
  localparam int unsigned AWidth    = 2 * CoordWidth;
  localparam int unsigned HWidth    = 2 * CoordWidth + 2;
  localparam int unsigned CWidth    = 2 * CoordWidth + 3;
  // split point for the wide products h*h and a*c
  localparam int unsigned SplitBits = CoordWidth + 1;
  localparam int unsigned HiHWidth  = HWidth - SplitBits;
  localparam int unsigned HiAWidth  = AWidth - SplitBits;
  localparam int unsigned HiCWidth  = CWidth - SplitBits;
  // full signed discriminant, and its range when non-negative (q <= a*R*R)
  localparam int unsigned PWidth    = 4 * CoordWidth + 4;
  localparam int unsigned QWidth    = 4 * CoordWidth - 2;
  localparam int unsigned SWidth    = 2 * CoordWidth - 1;
  // chosen root numerator and the divider remainder
  localparam int unsigned NWidth    = HWidth;
  localparam int unsigned RemWidth  = AWidth + DistBits;

  typedef struct packed {
    logic signed [CoordWidth-1:0] origin_x;
    logic signed [CoordWidth-1:0] origin_y;
    logic signed [CoordWidth-1:0] origin_z;
    logic signed [CoordWidth-1:0] dir_x;
    logic signed [CoordWidth-1:0] dir_y;
    logic signed [CoordWidth-1:0] dir_z;
    logic signed [CoordWidth-1:0] center_x;
    logic signed [CoordWidth-1:0] center_y;
    logic signed [CoordWidth-1:0] center_z;
    logic [RadWidth-1:0]          sphere_radius;
  } ray_t;

  typedef struct packed {
    logic                     valid;
    logic                     nohit;
    logic [AWidth-1:0]        a;
    logic signed [HWidth-1:0] h;
    logic [QWidth-1:0]        q;
  } quad_t;

  typedef struct packed {
    logic                     valid;
    logic                     nohit;
    logic [AWidth-1:0]        a;
    logic signed [HWidth-1:0] h;
    logic [SWidth-1:0]        s;
  } sqrt_t;

  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [DistBits-1:0] hit_distance;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/rsi_if.sv @@
// Request and result channels of the ray-sphere intersect block.
// Depends on rsi_pkg for the field widths.
`default_nettype none

interface rsi_ray_if;
  import rsi_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] origin_x;
  logic signed [CoordWidth-1:0] origin_y;
  logic signed [CoordWidth-1:0] origin_z;
  logic signed [CoordWidth-1:0] dir_x;
  logic signed [CoordWidth-1:0] dir_y;
  logic signed [CoordWidth-1:0] dir_z;
  logic signed [CoordWidth-1:0] center_x;
  logic signed [CoordWidth-1:0] center_y;
  logic signed [CoordWidth-1:0] center_z;
  logic [RadWidth-1:0]          sphere_radius;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    output center_x, center_y, center_z, sphere_radius,
    input  ready
  );

  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    input  center_x, center_y, center_z, sphere_radius,
    output ready
  );
endinterface

interface rsi_res_if;
  import rsi_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [DistBits-1:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rsi_quad.sv @@
// Front pipeline: difference, dot products, split wide products, discriminant.
// Six register stages; depends on rsi_pkg.
`default_nettype none

module rsi_quad (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  rsi_pkg::ray_t  ray_i,
  output rsi_pkg::quad_t quad_o
);
  import rsi_pkg::*;

  logic [5:0] vld_q;

  // stage 1
  logic signed [OcWidth-1:0]      oc_q [3];
  logic signed [CoordWidth-1:0]   d_q [3];
  logic [RadWidth-1:0]            rad_q;
  // stage 2
  logic signed [2*CoordWidth-1:0] dd_q [3];
  logic signed [2*CoordWidth:0]   doc_q [3];
  logic signed [2*CoordWidth+1:0] oo_q [3];
  logic [2*RadWidth-1:0]          rr_q;
  // stages 3..6
  logic [AWidth-1:0]              a3_q, a4_q, a5_q, a6_q;
  logic signed [HWidth-1:0]       h3_q, h4_q, h5_q, h6_q;
  logic signed [CWidth-1:0]       c3_q;
  logic signed [2*HiHWidth-1:0]           phh_q;
  logic signed [HiHWidth+SplitBits:0]     phl_q;
  logic [2*SplitBits-1:0]                 pll_q;
  logic signed [HiAWidth+HiCWidth:0]      pahch_q;
  logic [HiAWidth+SplitBits-1:0]          pahcl_q;
  logic signed [SplitBits+HiCWidth:0]     palch_q;
  logic [2*SplitBits-1:0]                 palcl_q;
  logic signed [PWidth-1:0]               hsq_q, ac_q;
  logic [QWidth-1:0]                      q_q;
  logic                                   nohit_q;

  logic signed [PWidth-1:0] e_hh, e_hl, e_ll, e_ahch, e_ahcl, e_alch, e_alcl;
  logic signed [PWidth-1:0] q_full;

  assign e_hh   = PWidth'(phh_q);
  assign e_hl   = PWidth'(phl_q);
  assign e_ll   = $signed(PWidth'(pll_q));
  assign e_ahch = PWidth'(pahch_q);
  assign e_ahcl = $signed(PWidth'(pahcl_q));
  assign e_alch = PWidth'(palch_q);
  assign e_alcl = $signed(PWidth'(palcl_q));

  assign q_full = hsq_q - ac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: OC = O - C
      oc_q[0] <= ray_i.origin_x - ray_i.center_x;
      oc_q[1] <= ray_i.origin_y - ray_i.center_y;
      oc_q[2] <= ray_i.origin_z - ray_i.center_z;
      d_q[0]  <= ray_i.dir_x;
      d_q[1]  <= ray_i.dir_y;
      d_q[2]  <= ray_i.dir_z;
      rad_q   <= ray_i.sphere_radius;
      // stage 2: component products
      for (int i = 0; i < 3; i++) begin
        dd_q[i]  <= d_q[i] * d_q[i];
        doc_q[i] <= d_q[i] * oc_q[i];
        oo_q[i]  <= oc_q[i] * oc_q[i];
      end
      rr_q <= rad_q * rad_q;
      // stage 3: a, h, c
      a3_q <= dd_q[0] + dd_q[1] + dd_q[2];
      h3_q <= doc_q[0] + doc_q[1] + doc_q[2];
      c3_q <= oo_q[0] + oo_q[1] + oo_q[2] - $signed({1'b0, rr_q});
      // stage 4: partial products of h*h and a*c
      phh_q   <= $signed(h3_q[HWidth-1:SplitBits]) * $signed(h3_q[HWidth-1:SplitBits]);
      phl_q   <= $signed(h3_q[HWidth-1:SplitBits]) * $signed({1'b0, h3_q[SplitBits-1:0]});
      pll_q   <= h3_q[SplitBits-1:0] * h3_q[SplitBits-1:0];
      pahch_q <= $signed({1'b0, a3_q[AWidth-1:SplitBits]}) *
                 $signed(c3_q[CWidth-1:SplitBits]);
      pahcl_q <= a3_q[AWidth-1:SplitBits] * c3_q[SplitBits-1:0];
      palch_q <= $signed({1'b0, a3_q[SplitBits-1:0]}) * $signed(c3_q[CWidth-1:SplitBits]);
      palcl_q <= a3_q[SplitBits-1:0] * c3_q[SplitBits-1:0];
      a4_q    <= a3_q;
      h4_q    <= h3_q;
      // stage 5: recombine
      hsq_q <= (e_hh <<< (2 * SplitBits)) + (e_hl <<< (SplitBits + 1)) + e_ll;
      ac_q  <= (e_ahch <<< (2 * SplitBits)) + ((e_ahcl + e_alch) <<< SplitBits) + e_alcl;
      a5_q  <= a4_q;
      h5_q  <= h4_q;
      // stage 6: discriminant and early reject
      q_q     <= q_full[QWidth-1:0];
      nohit_q <= (a5_q == '0) || q_full[PWidth-1];
      a6_q    <= a5_q;
      h6_q    <= h5_q;
    end
  end

  assign quad_o = '{valid: vld_q[5], nohit: nohit_q, a: a6_q, h: h6_q, q: q_q};

endmodule

`default_nettype wire

@@ rtl/core/rsi_sqrt.sv @@
// Pipelined floor square root of the discriminant, one root bit per stage.
// Carries a, h and the reject flag alongside; depends on rsi_pkg.
`default_nettype none

module rsi_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rsi_pkg::quad_t quad_i,
  output rsi_pkg::sqrt_t sqrt_o
);
  import rsi_pkg::*;

  typedef struct packed {
    logic                     nohit;
    logic [AWidth-1:0]        a;
    logic signed [HWidth-1:0] h;
    logic [QWidth-1:0]        rem;
    logic [SWidth-1:0]        root;
  } sq_stage_t;

  sq_stage_t         st_q [SWidth];
  sq_stage_t         st_d [SWidth];
  logic [SWidth-1:0] vld_q;

  always_comb begin
    sq_stage_t        src;
    logic [QWidth:0]  trial;
    src = '{nohit: quad_i.nohit, a: quad_i.a, h: quad_i.h, rem: quad_i.q, root: '0};
    for (int k = 0; k < SWidth; k++) begin
      // trial = 2*root*2^bit + 2^(2*bit) for bit = SWidth-1-k
      trial = ((QWidth+1)'(src.root) << (SWidth - k)) |
              ((QWidth+1)'(1) << (2 * (SWidth - 1 - k)));
      st_d[k] = src;
      if ({1'b0, src.rem} >= trial) begin
        st_d[k].rem  = QWidth'({1'b0, src.rem} - trial);
        st_d[k].root = src.root | (SWidth'(1) << (SWidth - 1 - k));
      end
      src = st_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SWidth-2:0], quad_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SWidth; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign sqrt_o = '{valid: vld_q[SWidth-1], nohit: st_q[SWidth-1].nohit,
                    a: st_q[SWidth-1].a, h: st_q[SWidth-1].h, s: st_q[SWidth-1].root};

endmodule

`default_nettype wire

@@ rtl/core/rsi_div.sv @@
// Root selection, saturation check and pipelined restoring divide by a.
// One quotient bit per stage, then the result register; depends on rsi_pkg.
`default_nettype none

module rsi_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rsi_pkg::sqrt_t sqrt_i,
  output rsi_pkg::res_t  res_o
);
  import rsi_pkg::*;

  typedef struct packed {
    logic                hit;
    logic                sat;
    logic [AWidth-1:0]   a;
    logic [RemWidth-1:0] rem;
    logic [DistBits-1:0] quo;
  } dv_stage_t;

  // root selection
  logic signed [HWidth:0] hx, sx, n1, n2;
  logic                   sel_vld_q, sel_hit_q;
  logic [NWidth-1:0]      sel_num_q;
  logic [AWidth-1:0]      sel_a_q;
  logic [RemWidth-1:0]    dividend;

  // division chain: entry 0 holds the saturation stage
  dv_stage_t           st_q [DistBits+1];
  dv_stage_t           st_d [DistBits+1];
  logic [DistBits:0]   vld_q;

  logic                out_vld_q, out_hit_q;
  logic [DistBits-1:0] out_dist_q;

  assign hx = (HWidth+1)'(sqrt_i.h);
  assign sx = $signed((HWidth+1)'(sqrt_i.s));
  assign n1 = -hx - sx;
  assign n2 = sx - hx;

  assign dividend = RemWidth'({sel_num_q, {FracBits{1'b0}}});

  always_comb begin
    logic [RemWidth-1:0] sub;
    st_d[0] = '{hit: sel_hit_q,
                sat: dividend >= (RemWidth'(sel_a_q) << DistBits),
                a:   sel_a_q,
                rem: dividend,
                quo: '0};
    for (int k = 0; k < DistBits; k++) begin
      sub         = RemWidth'(st_q[k].a) << (DistBits - 1 - k);
      st_d[k + 1] = st_q[k];
      if (st_q[k].rem >= sub) begin
        st_d[k + 1].rem = st_q[k].rem - sub;
        st_d[k + 1].quo = st_q[k].quo | (DistBits'(1) << (DistBits - 1 - k));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      sel_vld_q <= sqrt_i.valid;
      vld_q     <= {vld_q[DistBits-1:0], sel_vld_q};
      out_vld_q <= vld_q[DistBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // take the smaller root that is not negative
      sel_hit_q <= !sqrt_i.nohit && (!n1[HWidth] || !n2[HWidth]);
      sel_num_q <= !n1[HWidth] ? n1[NWidth-1:0] : n2[NWidth-1:0];
      sel_a_q   <= sqrt_i.a;
      for (int k = 0; k <= DistBits; k++) begin
        st_q[k] <= st_d[k];
      end
      out_hit_q <= st_q[DistBits].hit;
      if (!st_q[DistBits].hit) begin
        out_dist_q <= '0;
      end else if (st_q[DistBits].sat) begin
        out_dist_q <= '1;
      end else begin
        out_dist_q <= st_q[DistBits].quo;
      end
    end
  end

  assign res_o = '{valid: out_vld_q, hit: out_hit_q, hit_distance: out_dist_q};

endmodule

`default_nettype wire

@@ rtl/core/ray_sphere_intersect.sv @@
// Ray-sphere intersect top level: front quadratic, square root and divide pipelines.
// Depends on rsi_pkg, rsi_if, rsi_quad, rsi_sqrt and rsi_div.
//
//   channel  dir  handshake     payload
//   ray_i    in   valid/ready   origin, dir, center (signed), sphere_radius
//   res_o    out  valid/ready   hit, hit_distance
//
// One request per cycle while res_o is not stalled. The pipeline holds six front
// stages, one square-root stage per root bit, root select, saturation check, one
// divide stage per quotient bit, and the result register.
// Reset clears only the valid bits. A result held at res_o freezes the whole
// pipeline and deasserts ray_i.ready; nothing is dropped or repeated.
`default_nettype none

module ray_sphere_intersect (
  input  logic             clk_i,
  input  logic             rst_ni,
  rsi_ray_if.sink          ray_i,
  rsi_res_if.source        res_o
);
  import rsi_pkg::*;

  logic  en;
  ray_t  ray;
  quad_t quad;
  sqrt_t sq;
  res_t  res;

  // advance everything unless the result register is full and stalled
  assign en          = !res.valid || res_o.ready;
  assign ray_i.ready = en;

  assign ray = '{origin_x: ray_i.origin_x, origin_y: ray_i.origin_y,
                 origin_z: ray_i.origin_z, dir_x: ray_i.dir_x, dir_y: ray_i.dir_y,
                 dir_z: ray_i.dir_z, center_x: ray_i.center_x,
                 center_y: ray_i.center_y, center_z: ray_i.center_z,
                 sphere_radius: ray_i.sphere_radius};

  rsi_quad u_quad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ray_i.valid),
    .ray_i   (ray),
    .quad_o  (quad)
  );

  rsi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .quad_i (quad),
    .sqrt_o (sq)
  );

  rsi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .sqrt_i (sq),
    .res_o  (res)
  );

  assign res_o.valid        = res.valid;
  assign res_o.hit          = res.hit;
  assign res_o.hit_distance = res.hit_distance;

`ifndef SYNTHESIS
  a_nohit_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.hit |-> res_o.hit_distance == '0)
    else $error("miss reported with nonzero distance");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |-> !ray_i.ready)
    else $error("request taken while result stalled");

  a_live_needs_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq.valid && !sq.nohit |-> sq.a != '0)
    else $error("zero direction passed the reject stage");
`endif

endmodule

`default_nettype wire
